### hdl/wprd_pkg.sv
`default_nettype none
package wprd_pkg;

	localparam int MAX_COLUMNS = 4096;
	localparam int SAMPLE_BITS = 16;
	localparam int SPC_W = 24;
	localparam int HH_W = 11;
	localparam int CC_W = 13;
	localparam int COL_W = 12;
	localparam int POS_W = 28;
	localparam int END_W = 36;
	localparam int SUM_W = 48;
	localparam int CNT_W = 17;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SPC = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd2;

	localparam logic [SPC_W-1:0] SPC_MIN = 24'd256;

	typedef struct packed {
		logic [COL_W-1:0] column;
		logic [SAMPLE_BITS-1:0] peak;
		logic [SUM_W-1:0] sumsq;
		logic [CNT_W-1:0] count;
		logic last;
	} job_t;

	function automatic logic [SPC_W-1:0] eff_spc(input logic [SPC_W-1:0] v);
		return (v < SPC_MIN) ? SPC_MIN : v;
	endfunction

endpackage
`default_nettype wire

### hdl/wprd_if.sv
`default_nettype none
interface wprd_in_if;
	logic valid;
	logic ready;
	logic signed [wprd_pkg::SAMPLE_BITS-1:0] sample;
	logic last_of_buffer;
	modport source (output valid, output sample, output last_of_buffer, input ready);
	modport sink (input valid, input sample, input last_of_buffer, output ready);
endinterface

interface wprd_out_if;
	logic valid;
	logic ready;
	logic [wprd_pkg::COL_W-1:0] column;
	logic [wprd_pkg::HH_W-1:0] peak_height;
	logic [wprd_pkg::HH_W-1:0] rms_height;
	logic last_column;
	modport source (output valid, output column, output peak_height, output rms_height,
		output last_column, input ready);
	modport sink (input valid, input column, input peak_height, input rms_height,
		input last_column, output ready);
endinterface

interface wprd_cfg_if;
	logic valid;
	logic ready;
	logic [wprd_pkg::CFG_IDX_W-1:0] index;
	logic [wprd_pkg::SPC_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### hdl/wprd_front.sv
`default_nettype none
module wprd_front (
	input wire logic clk,
	input wire logic arst_n,
	wprd_in_if.sink samples,
	wprd_cfg_if.sink cfg,
	output logic [wprd_pkg::HH_W-1:0] half_height,
	output logic push,
	output wprd_pkg::job_t job,
	input wire logic full
);

	logic [wprd_pkg::SPC_W-1:0] spc_q;
	logic [wprd_pkg::HH_W-1:0] hh_q;
	logic [wprd_pkg::CC_W-1:0] cc_q;
	logic [wprd_pkg::POS_W-1:0] pos_q;
	logic [wprd_pkg::CC_W-1:0] cur_q;
	logic [wprd_pkg::END_W-1:0] end_q;
	logic [wprd_pkg::SAMPLE_BITS-1:0] peak_q;
	logic [wprd_pkg::SUM_W-1:0] sum_q;
	logic [wprd_pkg::CNT_W-1:0] cnt_q;

	logic take;
	logic [wprd_pkg::CC_W-1:0] cnt_eff;
	logic [wprd_pkg::SAMPLE_BITS-1:0] mag;
	logic [2*wprd_pkg::SAMPLE_BITS-1:0] sq;
	logic [wprd_pkg::SAMPLE_BITS-1:0] peak_n;
	logic [wprd_pkg::SUM_W-1:0] sum_n;
	logic [wprd_pkg::CNT_W-1:0] cnt_n;
	logic [wprd_pkg::POS_W-1:0] pos_n;
	logic active, close_col, final_col;

	assign samples.ready = !full;
	assign cfg.ready = 1'b1;
	assign take = samples.valid && samples.ready;
	assign half_height = hh_q;

	assign cnt_eff = (cc_q > wprd_pkg::CC_W'(wprd_pkg::MAX_COLUMNS)) ?
		wprd_pkg::CC_W'(wprd_pkg::MAX_COLUMNS) : cc_q;
	assign mag = samples.sample[wprd_pkg::SAMPLE_BITS-1] ?
		wprd_pkg::SAMPLE_BITS'(-samples.sample) : samples.sample;
	assign sq = mag * mag;
	assign peak_n = (mag > peak_q) ? mag : peak_q;
	assign sum_n = sum_q + wprd_pkg::SUM_W'(sq);
	assign cnt_n = cnt_q + 1'b1;
	assign pos_n = pos_q + 1'b1;
	assign active = cur_q < cnt_eff;
	assign close_col = pos_n >= end_q[wprd_pkg::END_W-1:8];
	assign final_col = ({1'b0, cur_q} + 1'b1) >= {1'b0, cnt_eff};

	assign push = take && active && (samples.last_of_buffer || close_col);
	assign job.column = cur_q[wprd_pkg::COL_W-1:0];
	assign job.peak = peak_n;
	assign job.sumsq = sum_n;
	assign job.count = cnt_n;
	assign job.last = samples.last_of_buffer || final_col;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spc_q <= wprd_pkg::SPC_MIN;
			hh_q <= wprd_pkg::HH_W'(30);
			cc_q <= wprd_pkg::CC_W'(1024);
			pos_q <= '0;
			cur_q <= '0;
			end_q <= wprd_pkg::END_W'(wprd_pkg::SPC_MIN);
			peak_q <= '0;
			sum_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					wprd_pkg::REG_SPC: begin
						spc_q <= cfg.data;
						if (pos_q == '0)
							end_q <= wprd_pkg::END_W'(wprd_pkg::eff_spc(cfg.data));
					end
					wprd_pkg::REG_HALF_HEIGHT: hh_q <= cfg.data[wprd_pkg::HH_W-1:0];
					wprd_pkg::REG_COLUMN_COUNT: cc_q <= cfg.data[wprd_pkg::CC_W-1:0];
					default: ;
				endcase
			end
			if (take) begin
				if (samples.last_of_buffer) begin
					pos_q <= '0;
					cur_q <= '0;
					end_q <= wprd_pkg::END_W'(wprd_pkg::eff_spc(spc_q));
					peak_q <= '0;
					sum_q <= '0;
					cnt_q <= '0;
				end else if (active) begin
					pos_q <= pos_n;
					if (close_col) begin
						cur_q <= cur_q + 1'b1;
						end_q <= end_q + wprd_pkg::END_W'(wprd_pkg::eff_spc(spc_q));
						peak_q <= '0;
						sum_q <= '0;
						cnt_q <= '0;
					end else begin
						peak_q <= peak_n;
						sum_q <= sum_n;
						cnt_q <= cnt_n;
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

### hdl/wprd_queue.sv
`default_nettype none
module wprd_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire wprd_pkg::job_t push_job,
	output logic full,
	input wire logic pop,
	output logic avail,
	output wprd_pkg::job_t head
);

	wprd_pkg::job_t mem_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] fill_q;

	assign full = fill_q[2];
	assign avail = fill_q != '0;
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full)
			mem_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			fill_q <= '0;
		end else begin
			if (push && !full)
				wr_q <= wr_q + 1'b1;
			if (pop && avail)
				rd_q <= rd_q + 1'b1;
			fill_q <= fill_q + 3'(push && !full) - 3'(pop && avail);
		end
	end

endmodule
`default_nettype wire

### hdl/wprd_back.sv
`default_nettype none
module wprd_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [wprd_pkg::HH_W-1:0] half_height,
	input wire logic avail,
	input wire wprd_pkg::job_t head,
	output logic pop,
	wprd_out_if.source results
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL0 = 3'd1;
	localparam logic [2:0] ST_MUL1 = 3'd2;
	localparam logic [2:0] ST_DIV = 3'd3;
	localparam logic [2:0] ST_SQI = 3'd4;
	localparam logic [2:0] ST_SQRT = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;
	localparam int PW = 2 * wprd_pkg::HH_W + wprd_pkg::SUM_W;
	localparam int SHIFT = 2 * (wprd_pkg::SAMPLE_BITS - 1);
	localparam int VW = 2 * wprd_pkg::HH_W + 1;

	logic [2:0] st_q;
	wprd_pkg::job_t job_q;
	logic [2*wprd_pkg::HH_W-1:0] hh2_q;
	logic [wprd_pkg::HH_W-1:0] peakh_q;
	logic [PW-1:0] prod_q;
	logic [wprd_pkg::CNT_W:0] rem_q;
	logic [6:0] it_q;
	logic [VW-1:0] v_q, r_q;
	logic [3:0] k_q;

	logic [wprd_pkg::CNT_W:0] rem_sh;
	logic qbit;
	logic [VW-1:0] bitv, rsum;
	logic [wprd_pkg::SAMPLE_BITS+wprd_pkg::HH_W-1:0] pk_prod;
	logic out_load;

	assign pop = (st_q == ST_IDLE) && avail;
	assign rem_sh = {rem_q[wprd_pkg::CNT_W-1:0], prod_q[PW-1]};
	assign qbit = rem_sh >= {1'b0, job_q.count};
	assign bitv = VW'(1) << {k_q, 1'b0};
	assign rsum = r_q + bitv;
	assign pk_prod = head.peak * half_height;
	assign out_load = (st_q == ST_DONE) && (!results.valid || results.ready);

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				job_q <= head;
				hh2_q <= half_height * half_height;
				peakh_q <= pk_prod[wprd_pkg::SAMPLE_BITS-1 +: wprd_pkg::HH_W];
			end
			ST_MUL0: prod_q <= PW'(hh2_q * job_q.sumsq[23:0]);
			ST_MUL1: begin
				prod_q <= prod_q + (PW'(hh2_q * job_q.sumsq[47:24]) << 24);
				rem_q <= '0;
				it_q <= 7'(PW - 1);
			end
			ST_DIV: begin
				prod_q <= {prod_q[PW-2:0], qbit};
				rem_q <= qbit ? rem_sh - {1'b0, job_q.count} : rem_sh;
				it_q <= it_q - 1'b1;
			end
			ST_SQI: begin
				v_q <= (job_q.count == '0) ? '0 : VW'(prod_q[SHIFT +: VW]);
				r_q <= '0;
				k_q <= 4'(wprd_pkg::HH_W - 1);
			end
			ST_SQRT: begin
				if (v_q >= rsum) begin
					v_q <= v_q - rsum;
					r_q <= (r_q >> 1) + bitv;
				end else begin
					r_q <= r_q >> 1;
				end
				k_q <= k_q - 1'b1;
			end
			default: ;
		endcase
		if (out_load) begin
			results.column <= job_q.column;
			results.peak_height <= peakh_q;
			results.rms_height <= r_q[wprd_pkg::HH_W-1:0];
			results.last_column <= job_q.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			results.valid <= 1'b0;
		end else begin
			if (out_load)
				results.valid <= 1'b1;
			else if (results.ready)
				results.valid <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (avail) st_q <= ST_MUL0;
				ST_MUL0: st_q <= ST_MUL1;
				ST_MUL1: st_q <= ST_DIV;
				ST_DIV: if (it_q == '0) st_q <= ST_SQI;
				ST_SQI: st_q <= ST_SQRT;
				ST_SQRT: if (k_q == '0) st_q <= ST_DONE;
				ST_DONE: if (out_load) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

### hdl/waveform_peak_rms_decimator_core.sv
// a sample that closes a column pushes a job into the four-entry column queue;
// the back end takes one job at a time, paced by its serial divider (70 steps)
// and square root (11 steps), and pops the next once its result is registered;
// samples flow one per cycle while the queue has room and stall once it fills
// reset: asynchronous, active low; restores register defaults and an empty buffer
`default_nettype none
module waveform_peak_rms_decimator_core (
	input wire logic clk,
	input wire logic arst_n,
	wprd_in_if.sink samples,
	wprd_cfg_if.sink cfg,
	wprd_out_if.source results
);

	logic [wprd_pkg::HH_W-1:0] half_height;
	logic push, full, pop, avail;
	wprd_pkg::job_t push_job, head;

	wprd_front u_front (
		.clk(clk), .arst_n(arst_n), .samples(samples), .cfg(cfg),
		.half_height(half_height), .push(push), .job(push_job), .full(full)
	);

	wprd_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_job(push_job), .full(full),
		.pop(pop), .avail(avail), .head(head)
	);

	wprd_back u_back (
		.clk(clk), .arst_n(arst_n), .half_height(half_height), .avail(avail),
		.head(head), .pop(pop), .results(results)
	);

endmodule
`default_nettype wire
